FILE: rtl/pfb_pkg.sv
// Package for the palette fade and blend engine.
// Holds the palette sizing, operation and register codes, sequencer types
// and the control bundle shared by the sequencer and the datapath.
package pfb_pkg;

   // Palette sizing.
   localparam int ENTRIES = 256;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int SPAN_W  = ((IDX_W > 8) ? IDX_W : 8) + 1;

   localparam logic [SPAN_W-1:0] ENTRIES_S = SPAN_W'(ENTRIES);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ENTRIES - 1);

   // Full scale of one colour channel.
   localparam logic [7:0] CHAN_MAX = 8'hFF;

   // Operation codes carried by a request beat; unused codes act as a read.
   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_FADE  = 3'd1,
      OP_WATER = 3'd2,
      OP_FLASH = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_FADE_RED    = 3'd0,
      CSR_FADE_GREEN  = 3'd1,
      CSR_FADE_BLUE   = 3'd2,
      CSR_FADE_ALPHA  = 3'd3,
      CSR_WATER_RED   = 3'd4,
      CSR_WATER_GREEN = 3'd5,
      CSR_WATER_BLUE  = 3'd6,
      CSR_WATER_ALPHA = 3'd7
   } csr_type;

   // Palette mode codes.
   typedef enum logic [1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_BLENDED = 2'd1,
      MODE_FLASH   = 2'd2
   } mode_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_FADE_PRIME,
      ST_FADE_BASE,
      ST_FADE_WATER,
      ST_WATER_PRIME,
      ST_WATER_RUN,
      ST_FLASH_RUN,
      ST_RSP_READ,
      ST_RSP_OUT
   } state_type;

   // Source of the palette write data.
   typedef enum logic [1:0] {
      WSEL_ZERO,
      WSEL_WHITE,
      WSEL_ENTRY,
      WSEL_BLEND
   } wsel_type;

   // Control bundle from the sequencer to the datapath.
   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic [IDX_W-1:0] wr_addr;
      logic             we_base;
      logic             we_water;
      logic             we_faded;
      logic             we_fwater;
      wsel_type         wsel;
      logic             src_water;
      logic             tint_water;
      logic             rsp_valid;
      logic             rsp_in_range;
   } ctrl_type;

endpackage

FILE: rtl/pfb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module pfb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; returns the contents before a same-cycle write.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pfb_blend.sv
// Shared blend unit: mixes one RGB888 pixel toward a tint colour.
// Depends on pfb_pkg for the channel full-scale constant.
module pfb_blend (
   input  logic [23:0] tint,
   input  logic [8:0]  alpha,
   input  logic [23:0] pixel,
   output logic [23:0] blended
);
   import pfb_pkg::*;

   logic [7:0]  sat_alpha;
   logic [7:0]  inv_alpha;
   logic [15:0] mix;

   // Saturate the weight, then (c*a + (255-a)*p) >> 8 on each channel.
   always_comb begin
      sat_alpha = (alpha > {1'b0, CHAN_MAX}) ? CHAN_MAX : alpha[7:0];
      inv_alpha = CHAN_MAX - sat_alpha;
      mix       = '0;
      blended   = '0;
      for (int ch = 0; ch < 3; ch++) begin
         mix = 16'(tint[ch*8 +: 8]) * 16'(sat_alpha)
             + 16'(pixel[ch*8 +: 8]) * 16'(inv_alpha);
         blended[ch*8 +: 8] = mix[15:8];
      end
   end

endmodule

FILE: rtl/pfb_seq.sv
// Sequencer for the palette fade and blend engine: clear pass, entry sweeps
// and response timing. Depends on pfb_pkg for state, op and control types.
module pfb_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_operation,
   input  logic [7:0]        req_first_index,
   input  logic [7:0]        req_last_index,
   output pfb_pkg::ctrl_type ctrl,
   output logic [1:0]        mode
);
   import pfb_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] end_ff, end_in;
   logic [7:0]       first_ff, first_in;
   mode_type         mode_ff, mode_in;

   logic             accept;
   logic             req_in_range;
   logic             first_in_range;
   logic [IDX_W-1:0] idx_next;
   logic             idx_done;

   // Map an 8-bit entry number onto the palette address width.
   function automatic logic [IDX_W-1:0] to_idx(input logic [7:0] value);
      return IDX_W'(SPAN_W'(value));
   endfunction

   assign busy           = (state_ff != ST_IDLE);
   assign accept         = start && !busy;
   assign req_in_range   = (SPAN_W'(req_first_index) < ENTRIES_S);
   assign first_in_range = (SPAN_W'(first_ff) < ENTRIES_S);
   assign idx_next       = idx_ff + IDX_W'(1);
   assign mode           = mode_ff;

   // State register and sweep counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         mode_ff  <= MODE_NORMAL;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         mode_ff  <= mode_in;
      end
   end

   // Request fields kept for the length of the operation.
   always_ff @(posedge clock) begin
      end_ff   <= end_in;
      first_ff <= first_in;
   end

   // Next state and control outputs.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      end_in    = end_ff;
      first_in  = first_ff;
      mode_in   = mode_ff;
      idx_done  = (idx_ff == end_ff);
      ctrl      = '0;
      ctrl.wsel = WSEL_ZERO;

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero every entry of all four palettes after reset.
            ctrl.wr_addr   = idx_ff;
            ctrl.we_base   = 1'b1;
            ctrl.we_water  = 1'b1;
            ctrl.we_faded  = 1'b1;
            ctrl.we_fwater = 1'b1;
            ctrl.wsel      = WSEL_ZERO;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_next;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               first_in = req_first_index;
               unique case (req_operation)
                  OP_WRITE: begin
                     state_in = ST_WRITE;
                  end
                  OP_FADE: begin
                     mode_in = MODE_BLENDED;
                     idx_in  = to_idx(req_first_index);
                     end_in  = (SPAN_W'(req_last_index) < ENTRIES_S) ?
                               to_idx(req_last_index) : LAST_IDX;
                     if (req_in_range && (req_first_index <= req_last_index)) begin
                        state_in = ST_FADE_PRIME;
                     end else begin
                        state_in = ST_RSP_READ;
                     end
                  end
                  OP_WATER: begin
                     mode_in  = MODE_BLENDED;
                     idx_in   = '0;
                     end_in   = LAST_IDX;
                     state_in = ST_WATER_PRIME;
                  end
                  OP_FLASH: begin
                     mode_in  = MODE_FLASH;
                     idx_in   = '0;
                     end_in   = LAST_IDX;
                     state_in = ST_FLASH_RUN;
                  end
                  default: begin
                     state_in = ST_RSP_READ;
                  end
               endcase
            end
         end

         ST_WRITE: begin
            ctrl.wr_addr = to_idx(first_ff);
            ctrl.we_base = first_in_range;
            ctrl.wsel    = WSEL_ENTRY;
            state_in     = ST_RSP_READ;
         end

         ST_FADE_PRIME: begin
            ctrl.rd_addr = idx_ff;
            state_in     = ST_FADE_BASE;
         end

         ST_FADE_BASE: begin
            // Hold the read address so the entry stays for the water half.
            ctrl.rd_addr  = idx_ff;
            ctrl.wr_addr  = idx_ff;
            ctrl.we_faded = 1'b1;
            ctrl.wsel     = WSEL_BLEND;
            state_in      = ST_FADE_WATER;
         end

         ST_FADE_WATER: begin
            // Fetch the next entry while the water half is written.
            ctrl.rd_addr   = idx_done ? idx_ff : idx_next;
            ctrl.wr_addr   = idx_ff;
            ctrl.we_fwater = 1'b1;
            ctrl.wsel      = WSEL_BLEND;
            ctrl.src_water = 1'b1;
            if (idx_done) begin
               state_in = ST_RSP_READ;
            end else begin
               idx_in   = idx_next;
               state_in = ST_FADE_BASE;
            end
         end

         ST_WATER_PRIME: begin
            ctrl.rd_addr = idx_ff;
            state_in     = ST_WATER_RUN;
         end

         ST_WATER_RUN: begin
            ctrl.rd_addr    = idx_done ? idx_ff : idx_next;
            ctrl.wr_addr    = idx_ff;
            ctrl.we_water   = 1'b1;
            ctrl.wsel       = WSEL_BLEND;
            ctrl.tint_water = 1'b1;
            if (idx_done) begin
               state_in = ST_RSP_READ;
            end else begin
               idx_in = idx_next;
            end
         end

         ST_FLASH_RUN: begin
            ctrl.wr_addr   = idx_ff;
            ctrl.we_fwater = 1'b1;
            ctrl.wsel      = WSEL_WHITE;
            if (idx_done) begin
               state_in = ST_RSP_READ;
            end else begin
               idx_in = idx_next;
            end
         end

         ST_RSP_READ: begin
            ctrl.rd_addr = first_in_range ? to_idx(first_ff) : '0;
            state_in     = ST_RSP_OUT;
         end

         ST_RSP_OUT: begin
            ctrl.rsp_valid    = 1'b1;
            ctrl.rsp_in_range = first_in_range;
            state_in          = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // An accepted beat makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after an accepted request");

   // After a result the block is ready for the next request.
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_valid |=> !busy)
      else $error("block still busy after a result");

   // A result only follows work in progress.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_valid |-> $past(busy))
      else $error("result strobe without an operation");

   // Palette addresses never leave the populated range.
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (SPAN_W'(ctrl.rd_addr) < ENTRIES_S) && (SPAN_W'(ctrl.wr_addr) < ENTRIES_S))
      else $error("palette address beyond the palette");

endmodule

FILE: rtl/palette_fade_blend_engine.sv
// Palette fade and blend engine: a read or an empty fade goes straight to the result,
// a base write writes its entry first, a fade blends its range, set water blends the
// whole palette and flash writes it white; the next beat is taken in the cycle after
// the result. Set water and flash sweep one entry per cycle; a fade blends twice per
// entry. Synchronous reset starts a clearing pass over all entries with busy high.
// Configuration writes are taken at all times, and results cannot be stalled.
module palette_fade_blend_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_first_index,
   input  logic [7:0]  req_last_index,
   input  logic [7:0]  req_entry_red,
   input  logic [7:0]  req_entry_green,
   input  logic [7:0]  req_entry_blue,
   output logic        rsp_valid,
   output logic [23:0] rsp_base_colour,
   output logic [23:0] rsp_water_colour,
   output logic [23:0] rsp_faded_colour,
   output logic [23:0] rsp_faded_water_colour,
   output logic [15:0] rsp_faded_rgb565,
   output logic [15:0] rsp_faded_water_rgb565,
   output logic [1:0]  rsp_palette_mode,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import pfb_pkg::*;

   ctrl_type    ctrl;
   logic [1:0]  mode;

   logic [7:0]  fade_red_ff, fade_green_ff, fade_blue_ff;
   logic [8:0]  fade_alpha_ff;
   logic [7:0]  water_red_ff, water_green_ff, water_blue_ff;
   logic [8:0]  water_alpha_ff;
   logic [23:0] entry_ff;

   logic [23:0] base_rd, water_rd, faded_rd, fwater_rd;
   logic [23:0] blend_tint, blend_pixel, blend_out, wr_data;
   logic [8:0]  blend_alpha;
   logic [23:0] faded_sel, fwater_sel;

   // Pack an RGB888 pixel into RGB565 from the top bits of each channel.
   function automatic logic [15:0] to_rgb565(input logic [23:0] px);
      return {px[23:19], px[15:10], px[7:3]};
   endfunction

   // Configuration registers; the port never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_red_ff    <= '0;
         fade_green_ff  <= '0;
         fade_blue_ff   <= '0;
         fade_alpha_ff  <= '0;
         water_red_ff   <= '0;
         water_green_ff <= '0;
         water_blue_ff  <= '0;
         water_alpha_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_type'(csr_index))
            CSR_FADE_RED:    fade_red_ff    <= csr_data[7:0];
            CSR_FADE_GREEN:  fade_green_ff  <= csr_data[7:0];
            CSR_FADE_BLUE:   fade_blue_ff   <= csr_data[7:0];
            CSR_FADE_ALPHA:  fade_alpha_ff  <= csr_data;
            CSR_WATER_RED:   water_red_ff   <= csr_data[7:0];
            CSR_WATER_GREEN: water_green_ff <= csr_data[7:0];
            CSR_WATER_BLUE:  water_blue_ff  <= csr_data[7:0];
            CSR_WATER_ALPHA: water_alpha_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Colour of a base write, captured with the request beat.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         entry_ff <= {req_entry_red, req_entry_green, req_entry_blue};
      end
   end

   // Sequencer.
   pfb_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .ctrl            (ctrl),
      .mode            (mode)
   );

   // Operand selection for the shared blend unit.
   assign blend_tint  = ctrl.tint_water ? {water_red_ff, water_green_ff, water_blue_ff}
                                        : {fade_red_ff, fade_green_ff, fade_blue_ff};
   assign blend_alpha = ctrl.tint_water ? water_alpha_ff : fade_alpha_ff;
   assign blend_pixel = ctrl.src_water ? water_rd : base_rd;

   pfb_blend u_blend (
      .tint    (blend_tint),
      .alpha   (blend_alpha),
      .pixel   (blend_pixel),
      .blended (blend_out)
   );

   // Write data shared by all four palettes.
   always_comb begin
      case (ctrl.wsel)
         WSEL_ZERO:  wr_data = '0;
         WSEL_WHITE: wr_data = {CHAN_MAX, CHAN_MAX, CHAN_MAX};
         WSEL_ENTRY: wr_data = entry_ff;
         WSEL_BLEND: wr_data = blend_out;
         default:    wr_data = '0;
      endcase
   end

   // Palette stores.
   pfb_ram #(.WIDTH(24), .DEPTH(ENTRIES)) u_base_ram (
      .clock   (clock),
      .wr_en   (ctrl.we_base),
      .wr_addr (ctrl.wr_addr),
      .wr_data (wr_data),
      .rd_addr (ctrl.rd_addr),
      .rd_data (base_rd)
   );

   pfb_ram #(.WIDTH(24), .DEPTH(ENTRIES)) u_water_ram (
      .clock   (clock),
      .wr_en   (ctrl.we_water),
      .wr_addr (ctrl.wr_addr),
      .wr_data (wr_data),
      .rd_addr (ctrl.rd_addr),
      .rd_data (water_rd)
   );

   pfb_ram #(.WIDTH(24), .DEPTH(ENTRIES)) u_faded_ram (
      .clock   (clock),
      .wr_en   (ctrl.we_faded),
      .wr_addr (ctrl.wr_addr),
      .wr_data (wr_data),
      .rd_addr (ctrl.rd_addr),
      .rd_data (faded_rd)
   );

   pfb_ram #(.WIDTH(24), .DEPTH(ENTRIES)) u_fwater_ram (
      .clock   (clock),
      .wr_en   (ctrl.we_fwater),
      .wr_addr (ctrl.wr_addr),
      .wr_data (wr_data),
      .rd_addr (ctrl.rd_addr),
      .rd_data (fwater_rd)
   );

   // Result beat; an index beyond the palette reads as black.
   assign faded_sel  = ctrl.rsp_in_range ? faded_rd  : '0;
   assign fwater_sel = ctrl.rsp_in_range ? fwater_rd : '0;

   assign rsp_valid              = ctrl.rsp_valid;
   assign rsp_base_colour        = ctrl.rsp_in_range ? base_rd  : '0;
   assign rsp_water_colour       = ctrl.rsp_in_range ? water_rd : '0;
   assign rsp_faded_colour       = faded_sel;
   assign rsp_faded_water_colour = fwater_sel;
   assign rsp_faded_rgb565       = to_rgb565(faded_sel);
   assign rsp_faded_water_rgb565 = to_rgb565(fwater_sel);
   assign rsp_palette_mode       = mode;

endmodule
